// ----- src/tcw_pkg.sv -----
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int ADDR_W  = $clog2(CELLS + 1);

    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_NUL       = 8'd0;
    localparam logic [7:0] DEFAULT_ATTR = 8'h07;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [3:0] {
        S_FETCH,
        S_PUT,
        S_LF,
        S_CHK,
        S_SCR0,
        S_SCR1,
        S_FILL,
        S_CLR,
        S_RST,
        S_READ,
        S_RES
    } t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_PUT,
        OP_LF,
        OP_SCR_START,
        OP_COPY,
        OP_FILL,
        OP_CLR,
        OP_READ,
        OP_RESULT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_LAST,
        C_ROW_OVF,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic row_ovf;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            S_FETCH: w = '{OP_FETCH,     C_DISPATCH, S_FETCH, S_FETCH};
            S_PUT:   w = '{OP_PUT,       C_ALWAYS,   S_CHK,   S_CHK};
            S_LF:    w = '{OP_LF,        C_LAST,     S_CHK,   S_LF};
            S_CHK:   w = '{OP_NOP,       C_ROW_OVF,  S_SCR0,  S_RES};
            S_SCR0:  w = '{OP_SCR_START, C_ALWAYS,   S_SCR1,  S_SCR1};
            S_SCR1:  w = '{OP_COPY,      C_LAST,     S_FILL,  S_SCR1};
            S_FILL:  w = '{OP_FILL,      C_LAST,     S_RES,   S_FILL};
            S_CLR:   w = '{OP_CLR,       C_LAST,     S_RES,   S_CLR};
            S_RST:   w = '{OP_CLR,       C_LAST,     S_FETCH, S_RST};
            S_READ:  w = '{OP_READ,      C_ALWAYS,   S_RES,   S_RES};
            S_RES:   w = '{OP_RESULT,    C_OUT_FREE, S_FETCH, S_RES};
            default: w = '{OP_NOP,       C_ALWAYS,   S_FETCH, S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- src/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tcw_useq.sv -----
module tcw_useq import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stat      i_stat,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_code,
    output t_op        o_op
);

    t_step  r_upc;
    t_step  n_upc;
    t_step  disp;
    t_uword uw;

    always_comb begin
        case (i_req_type)
            REQ_PUT: begin
                if (i_char_code == CH_LF) begin
                    disp = S_LF;
                end else if (i_char_code == CH_CR) begin
                    disp = S_RES;
                end else begin
                    disp = S_PUT;
                end
            end
            REQ_CLEAR: disp = S_CLR;
            REQ_READ:  disp = S_READ;
            default:   disp = S_RES;
        endcase
    end

    always_comb begin
        uw = ucode(r_upc);
        case (uw.cond)
            C_ALWAYS:   n_upc = uw.tgt_t;
            C_DISPATCH: n_upc = i_stat.in_valid ? disp : S_FETCH;
            C_LAST:     n_upc = i_stat.last ? uw.tgt_t : uw.tgt_f;
            C_ROW_OVF:  n_upc = i_stat.row_ovf ? uw.tgt_t : uw.tgt_f;
            C_OUT_FREE: n_upc = i_stat.out_free ? uw.tgt_t : uw.tgt_f;
            default:    n_upc = S_FETCH;
        endcase
    end

    always_comb begin
        o_op = uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_RST;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ----- src/tcw_dpath.sv -----
module tcw_dpath import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_stat       o_stat,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    input  logic        i_text_color_we,
    input  logic [7:0]  i_text_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr
);

    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [7:0]        r_color;
    logic [7:0]        r_char, n_char;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_rc, n_rc;
    logic [7:0]        r_ra, n_ra;
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_ocol, n_ocol;
    logic [4:0]        r_orow, n_orow;
    logic [7:0]        r_ochar, n_ochar;
    logic [7:0]        r_oattr, n_oattr;

    logic              acc;
    logic              in_range;
    logic              out_free;
    logic              last;
    logic [ADDR_W-1:0] cur_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we_c, we_a;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wd_c, wd_a;
    logic [7:0]        rd_c, rd_a;

    assign acc      = i_valid && (i_op == OP_FETCH);
    assign o_stall  = (i_op != OP_FETCH);
    assign in_range = (32'(i_cell_index) < CELLS);
    assign out_free = !r_out_valid || !i_stall;
    assign cur_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col));

    always_comb begin
        case (i_op)
            OP_LF:          last = (r_col == COL_W'(COLUMNS - 1));
            OP_COPY:        last = (r_addr == ADDR_W'(CELLS - COLUMNS - 1));
            OP_FILL, OP_CLR: last = (r_addr == ADDR_W'(CELLS - 1));
            default:        last = 1'b0;
        endcase
    end

    assign o_stat = '{in_valid: i_valid, last: last,
                      row_ovf: (r_row == ROW_W'(ROWS)), out_free: out_free};

    always_comb begin
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_char      = r_char;
        n_rd_ok     = r_rd_ok;
        n_rc        = r_rc;
        n_ra        = r_ra;
        n_out_valid = r_out_valid && i_stall;
        n_ocol      = r_ocol;
        n_orow      = r_orow;
        n_ochar     = r_ochar;
        n_oattr     = r_oattr;
        rd_en       = 1'b0;
        rd_addr     = ADDR_W'(i_cell_index);
        we_c        = 1'b0;
        we_a        = 1'b0;
        wr_addr     = r_addr;
        wd_c        = rd_c;
        wd_a        = rd_a;
        case (i_op)
            OP_FETCH: begin
                rd_en = acc && in_range && (i_req_type == REQ_READ);
                if (acc) begin
                    n_addr  = '0;
                    n_char  = i_char_code;
                    n_rd_ok = in_range;
                    n_rc    = '0;
                    n_ra    = '0;
                end
            end
            OP_PUT: begin
                we_c    = 1'b1;
                we_a    = 1'b1;
                wr_addr = cur_addr;
                wd_c    = r_char;
                wd_a    = r_color;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            OP_LF: begin
                we_a    = 1'b1;
                wr_addr = cur_addr;
                wd_a    = r_color;
                if (last) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            OP_SCR_START: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(COLUMNS);
                n_addr  = '0;
            end
            OP_COPY: begin
                we_c    = 1'b1;
                we_a    = 1'b1;
                rd_en   = !last;
                rd_addr = ADDR_W'(r_addr + ADDR_W'(COLUMNS + 1));
                n_addr  = r_addr + 1'b1;
            end
            OP_FILL: begin
                we_c   = 1'b1;
                we_a   = 1'b1;
                wd_c   = CH_SPACE;
                wd_a   = DEFAULT_ATTR;
                n_addr = r_addr + 1'b1;
                if (last) begin
                    n_row = ROW_W'(ROWS - 1);
                end
            end
            OP_CLR: begin
                we_c   = 1'b1;
                we_a   = 1'b1;
                wd_c   = CH_NUL;
                wd_a   = DEFAULT_ATTR;
                n_addr = r_addr + 1'b1;
                if (last) begin
                    n_col = '0;
                    n_row = '0;
                end
            end
            OP_READ: begin
                n_rc = r_rd_ok ? rd_c : 8'd0;
                n_ra = r_rd_ok ? rd_a : 8'd0;
            end
            OP_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ocol      = 7'(r_col);
                    n_orow      = 5'(r_row);
                    n_ochar     = r_rc;
                    n_oattr     = r_ra;
                end
            end
            default: begin
            end
        endcase
    end

    tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (we_c),
        .i_waddr ($clog2(CELLS)'(wr_addr)),
        .i_wdata (wd_c),
        .i_re    (rd_en),
        .i_raddr ($clog2(CELLS)'(rd_addr)),
        .o_rdata (rd_c)
    );

    tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr ($clog2(CELLS)'(wr_addr)),
        .i_wdata (wd_a),
        .i_re    (rd_en),
        .i_raddr ($clog2(CELLS)'(rd_addr)),
        .o_rdata (rd_a)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= DEFAULT_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            if (i_text_color_we) begin
                r_color <= i_text_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_rd_ok <= n_rd_ok;
        r_rc    <= n_rc;
        r_ra    <= n_ra;
        r_ocol  <= n_ocol;
        r_orow  <= n_orow;
        r_ochar <= n_ochar;
        r_oattr <= n_oattr;
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_ocol;
    assign o_cursor_row = r_orow;
    assign o_read_char  = r_ochar;
    assign o_read_attr  = r_oattr;

endmodule

// ----- src/text_console_writer.sv -----
// a put writes one cell and a read fetches one; carriage return and unused requests
//   skip to the result; line feed colors the rest of the row; clear wipes every cell
// a wrap or line feed past the last row adds a scroll (copy + blank row)
// throughput: one beat at a time, set by the one-cell-per-cycle sweeps of the sequencer
// reset: synchronous active low; afterwards a clearing pass runs with
//   o_stall high, color register writes are taken during it
module text_console_writer import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    input  logic        i_text_color_we,
    input  logic [7:0]  i_text_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr
);

    t_op   op;
    t_stat stat;

    tcw_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (stat),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .o_op        (op)
    );

    tcw_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_stat          (stat),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_text_color_we (i_text_color_we),
        .i_text_color    (i_text_color),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_read_char     (o_read_char),
        .o_read_attr     (o_read_attr)
    );

endmodule

// ----- src/tcw_checker.sv -----
module tcw_checker import tcw_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic [7:0]  o_read_char,
    input logic [7:0]  o_read_attr
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cursor_col) && $stable(o_cursor_row)
            && $stable(o_read_char) && $stable(o_read_attr))
        else $error("result beat changed while stalled");

    // one request in flight: input closes right after a beat is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an accepted beat");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_cursor_col) < COLUMNS) && (32'(o_cursor_row) < ROWS))
        else $error("cursor out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("activity right after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row),
    .o_read_char  (o_read_char),
    .o_read_attr  (o_read_attr)
);

// ----- tb/tb_text_console_writer.sv -----
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 150;
    localparam int DIR_ROWS    = 21;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] rchar;
        logic [7:0] rattr;
    } cell_result_t;

    typedef struct packed {
        logic [1:0]   req;
        logic [7:0]   ch;
        logic [10:0]  idx;
        logic         typed;
        cell_result_t res;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_char_code = '0;
    logic [10:0] i_cell_index = '0;
    logic        i_text_color_we = 1'b0;
    logic [7:0]  i_text_color = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [7:0]  o_read_char;
    logic [7:0]  o_read_attr;

    text_console_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_text_color_we (i_text_color_we),
        .i_text_color    (i_text_color),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_read_char     (o_read_char),
        .o_read_attr     (o_read_attr)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the console
    logic [7:0] shadow_char [CELLS];
    logic [7:0] shadow_attr [CELLS];
    int         shadow_col;
    int         shadow_row;
    logic [7:0] cur_color;

    cell_result_t pending_results [$];
    int error_count;
    bit quiet;

    int n_chars, n_lf, n_wraps, n_scrolls, n_clears, n_reads, n_unused, n_colors, n_items;

    function automatic void wipe_shadow();
        for (int k = 0; k < CELLS; k++) begin
            shadow_char[k] = CH_NUL;
            shadow_attr[k] = DEFAULT_ATTR;
        end
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    function automatic cell_result_t console_step(input logic [1:0] req, input logic [7:0] ch,
                                                  input logic [10:0] idx);
        cell_result_t r;
        int base;
        r = '0;
        case (req)
            REQ_PUT: begin
                base = shadow_row * COLUMNS;
                if (ch == CH_LF) begin
                    for (int k = shadow_col; k < COLUMNS; k++)
                        shadow_attr[base + k] = cur_color;
                    shadow_col = 0;
                    shadow_row++;
                    n_lf++;
                end else if (ch != CH_CR) begin
                    shadow_char[base + shadow_col] = ch;
                    shadow_attr[base + shadow_col] = cur_color;
                    shadow_col++;
                    n_chars++;
                    if (shadow_col >= COLUMNS) begin
                        shadow_col = 0;
                        shadow_row++;
                        n_wraps++;
                    end
                end
                if (shadow_row >= ROWS) begin
                    for (int k = 0; k < CELLS - COLUMNS; k++) begin
                        shadow_char[k] = shadow_char[k + COLUMNS];
                        shadow_attr[k] = shadow_attr[k + COLUMNS];
                    end
                    for (int k = CELLS - COLUMNS; k < CELLS; k++) begin
                        shadow_char[k] = CH_SPACE;
                        shadow_attr[k] = DEFAULT_ATTR;
                    end
                    shadow_row = ROWS - 1;
                    n_scrolls++;
                end
            end
            REQ_CLEAR: begin
                wipe_shadow();
                n_clears++;
            end
            REQ_READ: begin
                n_reads++;
                if (idx < CELLS) begin
                    r.rchar = shadow_char[idx];
                    r.rattr = shadow_attr[idx];
                end
            end
            default: n_unused++;
        endcase
        r.col = shadow_col[6:0];
        r.row = shadow_row[4:0];
        return r;
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                                input logic [10:0] idx, input bit typed,
                                input cell_result_t typed_res);
        cell_result_t r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_stall);
        r = console_step(req, ch, idx);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [7:0] c);
        i_text_color_we <= 1'b1;
        i_text_color    <= c;
        @(posedge i_clk);
        i_text_color_we <= 1'b0;
        cur_color = c;
        n_colors++;
    endtask

    // receiver stall bursts
    int  stall_left = 0;
    bit  stall_hold = 1'b0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_hold = ($urandom_range(0, 2) == 0);
            stall_left = $urandom_range(1, 10);
        end
        stall_left--;
        i_stall <= stall_hold && !quiet;
    end

    // result checker
    always @(posedge i_clk) begin
        cell_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected beat: col %0d row %0d char %0h attr %0h", $time,
                         o_cursor_col, o_cursor_row, o_read_char, o_read_attr);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_cursor_col !== e.col) begin
                    $display("%0t cursor_col: expected %0d, got %0d", $time, e.col, o_cursor_col);
                    error_count++;
                end
                if (o_cursor_row !== e.row) begin
                    $display("%0t cursor_row: expected %0d, got %0d", $time, e.row, o_cursor_row);
                    error_count++;
                end
                if (o_read_char !== e.rchar) begin
                    $display("%0t read_char: expected %0h, got %0h", $time, e.rchar, o_read_char);
                    error_count++;
                end
                if (o_read_attr !== e.rattr) begin
                    $display("%0t read_attr: expected %0h, got %0h", $time, e.rattr, o_read_attr);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #300000000;
        $display("TB_ERROR");
        $finish;
    end

    stim_row_t dir_tab [DIR_ROWS];

    initial begin
        int lf_pct;
        int pick;
        int near_row;
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic [7:0]  color;

        error_count = 0;
        quiet = 1'b0;
        cur_color = DEFAULT_ATTR;
        wipe_shadow();

        dir_tab[0]  = {REQ_READ,   8'h00,    11'd0,    1'b1, 7'd0, 5'd0, CH_NUL, DEFAULT_ATTR};
        dir_tab[1]  = {REQ_READ,   8'hFF,    11'd1999, 1'b1, 7'd0, 5'd0, CH_NUL, DEFAULT_ATTR};
        dir_tab[2]  = {REQ_READ,   8'h00,    11'd2000, 1'b1, 7'd0, 5'd0, 8'h00,  8'h00};
        dir_tab[3]  = {REQ_READ,   8'h55,    11'd2047, 1'b1, 7'd0, 5'd0, 8'h00,  8'h00};
        dir_tab[4]  = {REQ_UNUSED, 8'hFF,    11'd2047, 1'b1, 7'd0, 5'd0, 8'h00,  8'h00};
        dir_tab[5]  = {REQ_PUT,    8'h41,    11'd2047, 1'b1, 7'd1, 5'd0, 8'h00,  8'h00};
        dir_tab[6]  = {REQ_PUT,    8'hFF,    11'd0,    1'b1, 7'd2, 5'd0, 8'h00,  8'h00};
        dir_tab[7]  = {REQ_PUT,    CH_NUL,   11'd1024, 1'b1, 7'd3, 5'd0, 8'h00,  8'h00};
        dir_tab[8]  = {REQ_PUT,    CH_CR,    11'd0,    1'b1, 7'd3, 5'd0, 8'h00,  8'h00};
        dir_tab[9]  = {REQ_READ,   CH_LF,    11'd0,    1'b1, 7'd3, 5'd0, 8'h41,  DEFAULT_ATTR};
        dir_tab[10] = {REQ_READ,   8'h00,    11'd1,    1'b1, 7'd3, 5'd0, 8'hFF,  DEFAULT_ATTR};
        dir_tab[11] = {REQ_READ,   8'h00,    11'd2,    1'b1, 7'd3, 5'd0, CH_NUL, DEFAULT_ATTR};
        dir_tab[12] = {REQ_PUT,    CH_LF,    11'd2047, 1'b1, 7'd0, 5'd1, 8'h00,  8'h00};
        dir_tab[13] = {REQ_READ,   8'h00,    11'd79,   1'b1, 7'd0, 5'd1, CH_NUL, DEFAULT_ATTR};
        dir_tab[14] = {REQ_CLEAR,  CH_LF,    11'd5,    1'b1, 7'd0, 5'd0, 8'h00,  8'h00};
        dir_tab[15] = {REQ_READ,   8'h00,    11'd0,    1'b1, 7'd0, 5'd0, CH_NUL, DEFAULT_ATTR};
        dir_tab[16] = {REQ_PUT,    8'h80,    11'd3,    1'b0, 28'd0};
        dir_tab[17] = {REQ_READ,   8'h00,    11'd0,    1'b0, 28'd0};
        dir_tab[18] = {REQ_PUT,    CH_LF,    11'd0,    1'b0, 28'd0};
        dir_tab[19] = {REQ_READ,   8'hAA,    11'd2047, 1'b1, 7'd0, 5'd1, 8'h00,  8'h00};
        dir_tab[20] = {REQ_UNUSED, CH_LF,    11'd1,    1'b0, 28'd0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // the clearing pass after reset still takes color writes
        write_color(DEFAULT_ATTR);

        for (int k = 0; k < DIR_ROWS; k++)
            send_request(dir_tab[k].req, dir_tab[k].ch, dir_tab[k].idx, dir_tab[k].typed,
                         dir_tab[k].res);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       color = 8'h00;
                1:       color = 8'hFF;
                PHASES - 1: color = DEFAULT_ATTR;
                default: color = 8'($urandom_range(0, 255));
            endcase
            write_color(color);
            lf_pct = (p % 2 == 0) ? 3 : 22;
            quiet = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                ch   = 8'($urandom_range(0, 255));
                idx  = 11'($urandom_range(0, 2047));
                if (pick < 1) begin
                    req = REQ_CLEAR;
                end else if (pick < 3) begin
                    req = REQ_UNUSED;
                end else if (pick < 28) begin
                    req = REQ_READ;
                    pick = $urandom_range(0, 99);
                    near_row = (pick < 25 && shadow_row > 0) ? shadow_row - 1 : shadow_row;
                    if (pick < 50)
                        idx = 11'(near_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
                    else if (pick < 85)
                        idx = 11'($urandom_range(0, CELLS - 1));
                    else
                        idx = 11'($urandom_range(CELLS, 2047));
                end else begin
                    req = REQ_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < lf_pct)
                        ch = CH_LF;
                    else if (pick < lf_pct + 4)
                        ch = CH_CR;
                end
                send_request(req, ch, idx, 1'b0, '0);
            end
            drain_results();
        end

        repeat (4200) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_results.size());
            error_count++;
        end
        $display("run covered %0d requests: %0d characters, %0d line feeds, %0d row wraps, %0d scrolls",
                 n_items, n_chars, n_lf, n_wraps, n_scrolls);
        $display("  %0d clears, %0d cell reads, %0d unused requests, %0d color settings",
                 n_clears, n_reads, n_unused, n_colors);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_useq.sv
src/tcw_dpath.sv
src/text_console_writer.sv
src/tcw_checker.sv
tb/tb_text_console_writer.sv
